// ----- hw/rtl/spc_pkg.sv -----
// Shared constants and types for the super-prime checker.
// No dependencies; imported by super_prime_checker_unit.
package spc_pkg;

	// Data width of the value under test (low bits of the input are used).
	localparam int VALUE_BITS = 16;
	// Fixed field widths of the stream payloads.
	localparam int NUM_W      = 16;
	localparam int INDEX_W    = 13;
	localparam int INDEX_MAX  = 8191;
	localparam int S_DATA_W   = 16;
	localparam int M_DATA_W   = 16;

	// Derived widths.
	localparam int BIT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
	localparam int SQ_W  = VALUE_BITS + 2;
	localparam int CMP_W = (VALUE_BITS > INDEX_W) ? VALUE_BITS : INDEX_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TST_INIT,
		ST_TST_CHK,
		ST_TST_DIV,
		ST_TST_REM,
		ST_TST_END,
		ST_DONE
	} spc_state_t;

	// Which value the shared primality test is working on.
	typedef enum logic [1:0] {
		PH_NUM,
		PH_CNT,
		PH_IDX
	} spc_phase_t;

endpackage

// ----- hw/rtl/super_prime_checker_unit.sv -----
// Run time is data dependent: a prime input runs one trial-division test on the number,
// one per value 2..number and one for its index; a non-prime input runs only the first.
// Throughput: one item at a time; s_tready is high only while idle. The bit-serial
// remainder unit (one quotient bit per cycle) sets the pace. Reset (arst_n, async,
// active low) returns the sequencer to idle and drops m_tvalid.
// Depends on spc_pkg.
module super_prime_checker_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	// slave side: [15:0] number
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [spc_pkg::S_DATA_W-1:0] s_tdata,
	// master side: [0] is_prime, [13:1] prime_index, [14] is_super_prime, [15] zero
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [spc_pkg::M_DATA_W-1:0] m_tdata
);
	import spc_pkg::*;

	spc_state_t state_q, state_d;
	spc_phase_t phase_q;

	logic [VALUE_BITS-1:0] num_q;   // masked input value
	logic [VALUE_BITS-1:0] tv_q;    // value under test; also the running n while counting
	logic [VALUE_BITS-1:0] cnt_q;   // primes found so far
	logic [VALUE_BITS-1:0] d_q;     // current odd trial divisor
	logic [SQ_W-1:0]       sq_q;    // d_q squared, kept incrementally
	logic [VALUE_BITS-1:0] rem_q;   // partial remainder of tv_q / d_q
	logic [BIT_W-1:0]      bit_q;   // dividend bit being shifted in
	logic                  tres_q;  // outcome of the last test
	logic                  prime_q;
	logic                  super_q;

	logic                  m_tvalid_q;
	logic [M_DATA_W-1:0]   m_tdata_q;

	// Control decode
	logic                  accept;
	logic                  out_load;
	logic                  tv_small;   // below 2: not prime
	logic                  tv_tiny;    // below 4: prime unless tv_small
	logic                  sq_over;    // d*d > v: no divisor left
	logic [VALUE_BITS:0]   rem_shift;
	logic                  rem_ge;
	logic [VALUE_BITS-1:0] cnt_next;
	logic [INDEX_W-1:0]    index_sat;

	assign tv_small  = (tv_q < VALUE_BITS'(2));
	assign tv_tiny   = (tv_q < VALUE_BITS'(4));
	assign sq_over   = (sq_q > SQ_W'(tv_q));
	assign rem_shift = {rem_q, tv_q[bit_q]};
	assign rem_ge    = (rem_shift >= (VALUE_BITS + 1)'(d_q));
	assign cnt_next  = cnt_q + VALUE_BITS'(tres_q);

	// Index saturates at the field maximum.
	assign index_sat = (CMP_W'(cnt_q) > CMP_W'(INDEX_MAX)) ? INDEX_W'(INDEX_MAX)
	                                                         : INDEX_W'(cnt_q);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_TST_INIT;
			end
			ST_TST_INIT: begin
				if (tv_small || tv_tiny || !tv_q[0]) state_d = ST_TST_END;
				else state_d = ST_TST_CHK;
			end
			ST_TST_CHK: begin
				if (sq_over) state_d = ST_TST_END;
				else state_d = ST_TST_DIV;
			end
			ST_TST_DIV: begin
				if (bit_q == '0) state_d = ST_TST_REM;
			end
			ST_TST_REM: begin
				if (rem_q == '0) state_d = ST_TST_END;
				else state_d = ST_TST_CHK;
			end
			ST_TST_END: begin
				unique case (phase_q)
					PH_NUM:  state_d = tres_q ? ST_TST_INIT : ST_DONE;
					PH_CNT:  state_d = ST_TST_INIT;
					PH_IDX:  state_d = ST_DONE;
					default: state_d = ST_DONE;
				endcase
			end
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Handshake strobes
	always_comb begin
		s_tready = (state_q == ST_IDLE);
		accept   = s_tready && s_tvalid;
		out_load = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	// Datapath: one shared test unit, reused for number, every n, and the index
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					num_q   <= VALUE_BITS'(s_tdata[NUM_W-1:0]);
					tv_q    <= VALUE_BITS'(s_tdata[NUM_W-1:0]);
					phase_q <= PH_NUM;
					cnt_q   <= '0;
					prime_q <= 1'b0;
					super_q <= 1'b0;
				end
			end
			ST_TST_INIT: begin
				d_q  <= VALUE_BITS'(3);
				sq_q <= SQ_W'(9);
				if (tv_small) tres_q <= 1'b0;
				else if (tv_tiny) tres_q <= 1'b1;
				else if (!tv_q[0]) tres_q <= 1'b0;
			end
			ST_TST_CHK: begin
				rem_q <= '0;
				bit_q <= BIT_W'(VALUE_BITS - 1);
				if (sq_over) tres_q <= 1'b1;
			end
			ST_TST_DIV: begin
				// restoring remainder step, one dividend bit per cycle
				if (rem_ge) rem_q <= VALUE_BITS'(rem_shift - (VALUE_BITS + 1)'(d_q));
				else rem_q <= VALUE_BITS'(rem_shift);
				bit_q <= bit_q - BIT_W'(1);
			end
			ST_TST_REM: begin
				if (rem_q == '0) begin
					tres_q <= 1'b0;
				end else begin
					// (d+2)^2 = d^2 + 4d + 4
					sq_q <= sq_q + SQ_W'({d_q, 2'b00}) + SQ_W'(4);
					d_q  <= d_q + VALUE_BITS'(2);
				end
			end
			ST_TST_END: begin
				case (phase_q)
					PH_NUM: begin
						prime_q <= tres_q;
						if (tres_q) begin
							phase_q <= PH_CNT;
							tv_q    <= VALUE_BITS'(2);
						end
					end
					PH_CNT: begin
						cnt_q <= cnt_next;
						if (tv_q == num_q) begin
							phase_q <= PH_IDX;
							tv_q    <= cnt_next;
						end else begin
							tv_q <= tv_q + VALUE_BITS'(1);
						end
					end
					PH_IDX: super_q <= tres_q;
					default: super_q <= 1'b0;
				endcase
			end
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {1'b0, super_q, index_sat, prime_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ----- verif/spc_result_checker.sv -----
// Result checker for super_prime_checker_unit: watches both stream channels,
// predicts each result from the accepted number and compares field by field.
// Depends on spc_pkg for widths.
module spc_result_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	input  logic                         s_tready,
	input  logic [spc_pkg::S_DATA_W-1:0] s_tdata,
	input  logic                         m_tvalid,
	input  logic                         m_tready,
	input  logic [spc_pkg::M_DATA_W-1:0] m_tdata,
	input  logic                         at_end,
	output int                           errors
);
	import spc_pkg::*;

	typedef struct {
		logic [NUM_W-1:0]   number;
		logic               is_prime;
		logic [INDEX_W-1:0] index;
		logic               is_super;
	} verdict_t;

	verdict_t verdict_q[$];
	verdict_t want;
	logic     got_prime, got_super;
	logic [INDEX_W-1:0] got_index;
	bit       bad;
	bit       end_checked = 0;

	function automatic bit trial_prime(longint unsigned v);
		longint unsigned d;
		if (v < 2)
			return 0;
		if (v < 4)
			return 1;
		if (v % 2 == 0)
			return 0;
		for (d = 3; d * d <= v; d += 2) begin
			if (v % d == 0)
				return 0;
		end
		return 1;
	endfunction

	// Primality, rank among the primes (saturated) and primality of that rank.
	function automatic verdict_t classify(logic [S_DATA_W-1:0] raw);
		longint unsigned num, rank, n;
		verdict_t r;
		num = raw & ((64'd1 << VALUE_BITS) - 1);
		rank = 0;
		r.number = raw;
		r.is_prime = 1'b0;
		r.index = '0;
		r.is_super = 1'b0;
		if (trial_prime(num)) begin
			for (n = 2; n <= num; n++) begin
				if (trial_prime(n))
					rank++;
			end
			r.is_prime = 1'b1;
			r.index = (rank > INDEX_MAX) ? INDEX_W'(INDEX_MAX) : rank[INDEX_W-1:0];
			r.is_super = trial_prime(rank);
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			errors = 0;
			verdict_q.delete();
		end else begin
			if (s_tvalid && s_tready)
				verdict_q.push_back(classify(s_tdata));
			if (m_tvalid && m_tready) begin
				if (verdict_q.size() == 0) begin
					$display("%0t: result beat %h with no number pending", $time, m_tdata);
					errors++;
				end else begin
					want = verdict_q.pop_front();
					got_prime = m_tdata[0];
					got_index = m_tdata[INDEX_W:1];
					got_super = m_tdata[INDEX_W+1];
					bad = 0;
					if (got_prime !== want.is_prime) begin
						$display("%0t: number %0d is_prime expected %0b actual %0b",
							$time, want.number, want.is_prime, got_prime);
						bad = 1;
					end
					if (got_index !== want.index) begin
						$display("%0t: number %0d prime_index expected %0d actual %0d",
							$time, want.number, want.index, got_index);
						bad = 1;
					end
					if (got_super !== want.is_super) begin
						$display("%0t: number %0d is_super_prime expected %0b actual %0b",
							$time, want.number, want.is_super, got_super);
						bad = 1;
					end
					if (m_tdata[M_DATA_W-1:INDEX_W+2] !== '0) begin
						$display("%0t: number %0d pad bits expected 0 actual %b",
							$time, want.number, m_tdata[M_DATA_W-1:INDEX_W+2]);
						bad = 1;
					end
					if (bad)
						errors++;
				end
			end
			if (at_end && !end_checked) begin
				end_checked = 1;
				if (verdict_q.size() != 0) begin
					$display("%0t: %0d results expected but never returned",
						$time, verdict_q.size());
					errors++;
				end
			end
		end
	end

endmodule

// ----- verif/super_prime_checker_unit_tb.sv -----
// Testbench top for super_prime_checker_unit: drives numbers, paces the result
// channel and gives the verdict. Needs spc_pkg, the unit and spc_result_checker.
module super_prime_checker_unit_tb;
	import spc_pkg::*;

	localparam int HALF_PERIOD  = 6;
	localparam int RESET_CYCLES = 10;
	localparam int RANDOM_ITEMS = 77;
	// Watchdog limit, set far above the slowest expected run.
	localparam longint CYCLE_LIMIT = 20_000_000;
	localparam int HOLD_CYCLES  = 3000;
	localparam int TAIL_CYCLES  = 64;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic [S_DATA_W-1:0] s_tdata  = '0;
	logic                m_tready = 1'b0;
	logic                s_tready;
	logic                m_tvalid;
	logic [M_DATA_W-1:0] m_tdata;
	logic                at_end   = 1'b0;
	int                  errors;

	int     sent     = 0;
	int     returned = 0;
	longint cycles   = 0;
	bit     calm     = 0;

	always #HALF_PERIOD clk = ~clk;

	super_prime_checker_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	spc_result_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.at_end   (at_end),
		.errors   (errors)
	);

	// Beat counters and watchdog.
	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			sent <= sent + 1;
		if (m_tvalid && m_tready)
			returned <= returned + 1;
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL super_prime_checker_unit");
			$finish;
		end
	end

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Numbers are kept cheap: primes only in the low range (counting their rank
	// is the slow path), large values are even or a product of two odd factors.
	function automatic logic [S_DATA_W-1:0] draw_number();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return S_DATA_W'($urandom_range(0, 255));
		if (r < 55)
			return S_DATA_W'($urandom_range(256, 700));
		if (r < 78)
			return S_DATA_W'($urandom_range(0, 65535)) & 16'hFFFE;
		return S_DATA_W'(($urandom_range(1, 127) * 2 + 1) * ($urandom_range(1, 127) * 2 + 1));
	endfunction

	// Called at a falling edge; returns at the falling edge after the beat.
	// tvalid stays high on return so a back-to-back number needs no toggle.
	task automatic feed_number(input logic [S_DATA_W-1:0] number);
		int gap;
		gap = calm ? 0 : idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= number;
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	// Result side: random stalls, plus one long hold-off early on so the unit
	// parks a finished result and back-pressures its input.
	initial begin : receiver
		int stall;
		bit held;
		stall = 0;
		held  = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && returned >= 12) begin
				held = 1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else if (stall > 0) begin
				m_tready <= 1'b0;
				stall--;
			end else begin
				m_tready <= 1'b1;
				if (!calm)
					stall = idle_len();
			end
		end
	end

	initial begin : stimulus
		// zero/one, index one (2), small super primes (3, 5, 11, 31, 127, 991),
		// prime squares, odd composites with large factors, all-ones and
		// alternating patterns, a power of two
		logic [S_DATA_W-1:0] corner[] = '{
			16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd11, 16'd31, 16'd9,
			16'd25, 16'd49, 16'd169, 16'd127, 16'd131, 16'd255, 16'd256,
			16'd991, 16'hFFFF, 16'hFFFE, 16'd64507, 16'h8000, 16'hAAAA,
			16'h5555
		};
		int k;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (corner[i])
			feed_number(corner[i]);
		// let the unit drain completely before the random part
		s_tvalid <= 1'b0;
		while (returned != sent)
			@(negedge clk);
		for (k = 0; k < RANDOM_ITEMS; k++) begin
			calm = (k >= 40 && k < 60);
			feed_number(draw_number());
		end
		calm = 0;
		s_tvalid <= 1'b0;
		while (returned != sent)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		at_end = 1'b1;
		repeat (2) @(negedge clk);
		if (errors == 0)
			$display("PASS super_prime_checker_unit");
		else
			$display("FAIL super_prime_checker_unit");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/spc_pkg.sv
hw/rtl/super_prime_checker_unit.sv
verif/spc_result_checker.sv
verif/super_prime_checker_unit_tb.sv
